/* rtl/bellman_ford_shortest_path_tree_top_macros.svh */
// Assertion macros shared by the shortest-path-tree block.
`ifndef BELLMAN_FORD_SHORTEST_PATH_TREE_TOP_MACROS_SVH
`define BELLMAN_FORD_SHORTEST_PATH_TREE_TOP_MACROS_SVH

// Condition must never hold outside reset.
`define BFSPT_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define BFSPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/bfspt_pkg.sv */
// Shared types and constants of the shortest-path-tree block.
package bfspt_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_EDGES_DEF    = 1024;
    localparam int DIST_WIDTH_DEF   = 32;

    localparam int CMD_W  = 2;
    localparam int VTX_W  = 7;
    localparam int WGT_W  = 16;
    // wide enough for any vertex number or count up to 1024
    localparam int NUM_W  = 11;
    localparam int KW     = 6;
    localparam int MAX_RESULTS = 63;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_RUN   = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_ROUND,
        S_POP,
        S_POPW,
        S_DREAD,
        S_ERD,
        S_ECHK,
        S_ERLX,
        S_VSCAN,
        S_VPAR,
        S_WRD,
        S_WCHK,
        S_PUSHRES,
        S_FINAL
    } state_t;

endpackage

/* rtl/bfspt_if.sv */
// Request, result and configuration channel interfaces.
interface bfspt_req_if;
    logic                           valid;
    logic                           ready;
    logic [bfspt_pkg::CMD_W-1:0]    cmd;
    logic [bfspt_pkg::VTX_W-1:0]    edge_from;
    logic [bfspt_pkg::VTX_W-1:0]    edge_to;
    logic signed [bfspt_pkg::WGT_W-1:0] edge_weight;
    logic [bfspt_pkg::VTX_W-1:0]    source_vertex;

    modport source (output valid, cmd, edge_from, edge_to, edge_weight, source_vertex,
                    input ready);
    modport sink (input valid, cmd, edge_from, edge_to, edge_weight, source_vertex,
                  output ready);
endinterface

interface bfspt_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [bfspt_pkg::VTX_W-1:0]    tree_parent;
    logic [bfspt_pkg::VTX_W-1:0]    tree_vertex;
    logic signed [bfspt_pkg::WGT_W-1:0] tree_edge_weight;
    logic                           found;
    logic                           last;

    modport source (output valid, tree_parent, tree_vertex, tree_edge_weight, found, last,
                    input ready);
    modport sink (input valid, tree_parent, tree_vertex, tree_edge_weight, found, last,
                  output ready);
endinterface

interface bfspt_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bfspt_pkg::VTX_W-1:0]    vertex_count;

    modport source (output valid, vertex_count, input ready);
    modport sink (input valid, vertex_count, output ready);
endinterface

/* rtl/bellman_ford_shortest_path_tree_top.sv */
// Round-based Bellman-Ford engine emitting a shortest-path tree.
//
// Channels: req carries clear, add-edge and run requests; rsp returns tree
// edges; cfg writes vertex_count and is always ready, so write it only while idle.
// Clear and add are handled in the idle state, so edges load one per cycle.
// A run holds req.ready low until its last result is in the output register.
// One shared relax unit walks the edge store: every popped vertex scans all
// E stored edges and relaxes the D of them leaving that vertex within range
// and not self-loops; a round pops every vertex queued before it began, and at
// most vertex_count-1 rounds run after a setup state.
// Emission then searches the stored edges in load order for each tree edge,
// stopping at the parent edge, and visits every vertex in turn.
// Reset clears the edge count, the vertex count to 1 and the work queue; no
// memory sweep is needed. A stalled receiver holds the output register, and
// the emission sequencer waits, once a pending result must move on, until it is taken.
`include "bellman_ford_shortest_path_tree_top_macros.svh"

module bellman_ford_shortest_path_tree_top #(
    parameter int MAX_VERTICES = bfspt_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = bfspt_pkg::MAX_EDGES_DEF,
    parameter int DIST_WIDTH   = bfspt_pkg::DIST_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    bfspt_req_if.sink   req,
    bfspt_rsp_if.source rsp,
    bfspt_cfg_if.sink   cfg
);

    localparam int VW  = $clog2(MAX_VERTICES + 1);
    localparam int UW  = $clog2(MAX_VERTICES);
    localparam int ETW = $clog2(MAX_EDGES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int FD  = 2 * MAX_EDGES + 2;
    localparam int FAW = $clog2(FD);
    localparam int FCW = $clog2(FD + 1);
    localparam int DW  = DIST_WIDTH;
    localparam int NW  = bfspt_pkg::NUM_W;
    localparam int TW  = bfspt_pkg::VTX_W;
    localparam int WW  = bfspt_pkg::WGT_W;
    localparam int KW  = bfspt_pkg::KW;

    // memories
    logic [TW-1:0]          efrom_mem [MAX_EDGES];
    logic [TW-1:0]          eto_mem   [MAX_EDGES];
    logic [WW-1:0]          ewgt_mem  [MAX_EDGES];
    logic [DW-1:0]          dcur_mem  [MAX_VERTICES];
    logic [DW-1:0]          dprv_mem  [MAX_VERTICES];
    logic [VW-1:0]          dupd_mem  [MAX_VERTICES];
    logic [VW-1:0]          dpar_mem  [MAX_VERTICES];
    logic [UW-1:0]          fifo_mem  [FD];

    logic [TW-1:0]          efrom_q, eto_q;
    logic [WW-1:0]          ewgt_q;
    logic [DW-1:0]          dcur_q, dprv_q;
    logic [VW-1:0]          dupd_q, dpar_q;
    logic [UW-1:0]          fifo_q;

    // memory controls
    logic                   e_we, e_re;
    logic [EAW-1:0]         e_waddr, e_raddr;
    logic                   d_we, d_re;
    logic [UW-1:0]          d_waddr, d_raddr;
    logic [DW-1:0]          d_wcur, d_wprv;
    logic [VW-1:0]          d_wupd, d_wpar;
    logic                   f_we, f_re;
    logic [FAW-1:0]         f_waddr;
    logic [UW-1:0]          f_wdata;

    // registers
    bfspt_pkg::state_t      state_reg, state_next;
    logic [TW-1:0]          vc_reg;
    logic [ETW-1:0]         etot_reg, etot_next;
    logic [MAX_VERTICES-1:0] reached_reg, reached_next;
    logic [FAW-1:0]         fhead_reg, fhead_next;
    logic [FCW-1:0]         fcnt_reg, fcnt_next;
    logic [FCW-1:0]         pcnt_reg, pcnt_next;
    logic [VW-1:0]          round_reg, round_next;
    logic [NW-1:0]          src_reg, src_next;
    logic [UW-1:0]          u_reg, u_next;
    logic [UW-1:0]          x_reg, x_next;
    logic [DW-1:0]          dprev_reg, dprev_next;
    logic [WW-1:0]          w_reg, w_next;
    logic [ETW-1:0]         eidx_reg, eidx_next;
    logic [VW-1:0]          vi_reg, vi_next;
    logic [VW-1:0]          par_reg, par_next;
    logic [KW-1:0]          k_reg, k_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [TW-1:0]          pend_par_reg, pend_par_next;
    logic [TW-1:0]          pend_vtx_reg, pend_vtx_next;
    logic [WW-1:0]          pend_wgt_reg, pend_wgt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [TW-1:0]          out_par_reg, out_par_next;
    logic [TW-1:0]          out_vtx_reg, out_vtx_next;
    logic [WW-1:0]          out_wgt_reg, out_wgt_next;
    logic                   out_found_reg, out_found_next;
    logic                   out_last_reg, out_last_next;

    // datapath
    logic [NW-1:0]          n_w, vcx;
    logic [NW-1:0]          ef_w, et_w, rf_w, rt_w, sx_w;
    logic                   out_free;
    logic [DW:0]            sum_w, wext_w;
    logic [DW-1:0]          cand_w;
    logic                   take_w;
    logic [FCW:0]           tail_w;
    logic                   req_acc;

    assign req_acc = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    // clamp vertex count to 1..MAX_VERTICES
    always_comb
    begin
        vcx = NW'(vc_reg);
        if (vcx == '0)
            n_w = NW'(1);
        else if (vcx > NW'(MAX_VERTICES))
            n_w = NW'(MAX_VERTICES);
        else
            n_w = vcx;
    end

    assign ef_w = NW'(efrom_q);
    assign et_w = NW'(eto_q);
    assign rf_w = NW'(req.edge_from);
    assign rt_w = NW'(req.edge_to);
    assign sx_w = NW'(req.source_vertex);

    // saturating add of the edge weight to the popped vertex's distance
    always_comb
    begin
        wext_w = {{(DW + 1 - WW){w_reg[WW-1]}}, w_reg};
        sum_w  = {dprev_reg[DW-1], dprev_reg} + wext_w;
        if (sum_w[DW] != sum_w[DW-1])
            cand_w = sum_w[DW] ? {1'b1, {(DW - 1){1'b0}}} : {1'b0, {(DW - 1){1'b1}}};
        else
            cand_w = sum_w[DW-1:0];
        take_w = !reached_reg[x_reg] || ($signed(cand_w) < $signed(dcur_q));
    end

    assign tail_w = (FCW + 1)'(fhead_reg) + (FCW + 1)'(fcnt_reg);

    always_comb
    begin
        state_next      = state_reg;
        etot_next       = etot_reg;
        reached_next    = reached_reg;
        fhead_next      = fhead_reg;
        fcnt_next       = fcnt_reg;
        pcnt_next       = pcnt_reg;
        round_next      = round_reg;
        src_next        = src_reg;
        u_next          = u_reg;
        x_next          = x_reg;
        dprev_next      = dprev_reg;
        w_next          = w_reg;
        eidx_next       = eidx_reg;
        vi_next         = vi_reg;
        par_next        = par_reg;
        k_next          = k_reg;
        pend_valid_next = pend_valid_reg;
        pend_par_next   = pend_par_reg;
        pend_vtx_next   = pend_vtx_reg;
        pend_wgt_next   = pend_wgt_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_par_next    = out_par_reg;
        out_vtx_next    = out_vtx_reg;
        out_wgt_next    = out_wgt_reg;
        out_found_next  = out_found_reg;
        out_last_next   = out_last_reg;

        e_we    = 1'b0;
        e_waddr = etot_reg[EAW-1:0];
        e_re    = 1'b0;
        e_raddr = eidx_reg[EAW-1:0];
        d_we    = 1'b0;
        d_waddr = x_reg;
        d_wcur  = cand_w;
        d_wprv  = (dupd_q == round_reg) ? dprv_q : dcur_q;
        d_wupd  = round_reg;
        d_wpar  = VW'(NW'(u_reg) + NW'(1));
        d_re    = 1'b0;
        d_raddr = u_reg;
        f_we    = 1'b0;
        f_waddr = (tail_w >= (FCW + 1)'(FD)) ? FAW'(tail_w - (FCW + 1)'(FD)) : FAW'(tail_w);
        f_wdata = x_reg;
        f_re    = 1'b0;

        unique case (state_reg)
            bfspt_pkg::S_IDLE:
            begin
                if (req_acc)
                begin
                    case (req.cmd)
                        bfspt_pkg::CMD_CLEAR:
                            etot_next = '0;
                        bfspt_pkg::CMD_ADD:
                        begin
                            if (etot_reg < ETW'(MAX_EDGES) && rf_w != '0 && rf_w <= n_w
                                && rt_w != '0 && rt_w <= n_w)
                            begin
                                e_we      = 1'b1;
                                etot_next = etot_reg + ETW'(1);
                            end
                        end
                        bfspt_pkg::CMD_RUN:
                        begin
                            src_next        = sx_w;
                            pend_valid_next = 1'b0;
                            if (sx_w == '0 || sx_w > n_w)
                                state_next = bfspt_pkg::S_FINAL;
                            else
                                state_next = bfspt_pkg::S_INIT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            bfspt_pkg::S_INIT:
            begin
                reached_next = '0;
                reached_next[UW'(src_reg - NW'(1))] = 1'b1;
                d_we       = 1'b1;
                d_waddr    = UW'(src_reg - NW'(1));
                d_wcur     = '0;
                d_wprv     = '0;
                d_wupd     = '0;
                d_wpar     = '0;
                f_we       = 1'b1;
                f_waddr    = '0;
                f_wdata    = UW'(src_reg - NW'(1));
                fhead_next = '0;
                fcnt_next  = FCW'(1);
                round_next = VW'(1);
                state_next = bfspt_pkg::S_ROUND;
            end
            bfspt_pkg::S_ROUND:
            begin
                if (NW'(round_reg) >= n_w || fcnt_reg == '0)
                begin
                    vi_next    = '0;
                    k_next     = '0;
                    state_next = bfspt_pkg::S_VSCAN;
                end
                else
                begin
                    pcnt_next  = fcnt_reg;
                    state_next = bfspt_pkg::S_POP;
                end
            end
            bfspt_pkg::S_POP:
            begin
                f_re       = 1'b1;
                fhead_next = (fhead_reg == FAW'(FD - 1)) ? '0 : fhead_reg + FAW'(1);
                fcnt_next  = fcnt_reg - FCW'(1);
                pcnt_next  = pcnt_reg - FCW'(1);
                state_next = bfspt_pkg::S_POPW;
            end
            bfspt_pkg::S_POPW:
            begin
                u_next     = fifo_q;
                d_re       = 1'b1;
                d_raddr    = fifo_q;
                state_next = bfspt_pkg::S_DREAD;
            end
            bfspt_pkg::S_DREAD:
            begin
                // distance as it stood at the start of this round
                dprev_next = (dupd_q == round_reg) ? dprv_q : dcur_q;
                eidx_next  = '0;
                state_next = bfspt_pkg::S_ERD;
            end
            bfspt_pkg::S_ERD:
            begin
                if (eidx_reg == etot_reg)
                begin
                    if (pcnt_reg == '0)
                    begin
                        round_next = round_reg + VW'(1);
                        state_next = bfspt_pkg::S_ROUND;
                    end
                    else
                        state_next = bfspt_pkg::S_POP;
                end
                else
                begin
                    e_re       = 1'b1;
                    state_next = bfspt_pkg::S_ECHK;
                end
            end
            bfspt_pkg::S_ECHK:
            begin
                // outgoing edge of u within range, self-loops dropped
                if (ef_w == NW'(u_reg) + NW'(1) && ef_w <= n_w && et_w <= n_w
                    && ef_w != et_w)
                begin
                    x_next     = UW'(et_w - NW'(1));
                    w_next     = ewgt_q;
                    d_re       = 1'b1;
                    d_raddr    = UW'(et_w - NW'(1));
                    state_next = bfspt_pkg::S_ERLX;
                end
                else
                begin
                    eidx_next  = eidx_reg + ETW'(1);
                    state_next = bfspt_pkg::S_ERD;
                end
            end
            bfspt_pkg::S_ERLX:
            begin
                if (take_w)
                begin
                    d_we = 1'b1;
                    reached_next[x_reg] = 1'b1;
                    if (fcnt_reg < FCW'(FD))
                    begin
                        f_we      = 1'b1;
                        fcnt_next = fcnt_reg + FCW'(1);
                    end
                end
                eidx_next  = eidx_reg + ETW'(1);
                state_next = bfspt_pkg::S_ERD;
            end
            bfspt_pkg::S_VSCAN:
            begin
                if (NW'(vi_reg) == n_w)
                    state_next = bfspt_pkg::S_FINAL;
                else if (NW'(vi_reg) != src_reg - NW'(1) && reached_reg[UW'(vi_reg)]
                         && k_reg < KW'(bfspt_pkg::MAX_RESULTS))
                begin
                    d_re       = 1'b1;
                    d_raddr    = UW'(vi_reg);
                    state_next = bfspt_pkg::S_VPAR;
                end
                else
                    vi_next = vi_reg + VW'(1);
            end
            bfspt_pkg::S_VPAR:
            begin
                par_next   = dpar_q;
                eidx_next  = '0;
                state_next = bfspt_pkg::S_WRD;
            end
            bfspt_pkg::S_WRD:
            begin
                if (eidx_reg == etot_reg)
                begin
                    w_next     = '0;
                    state_next = bfspt_pkg::S_PUSHRES;
                end
                else
                begin
                    e_re       = 1'b1;
                    state_next = bfspt_pkg::S_WCHK;
                end
            end
            bfspt_pkg::S_WCHK:
            begin
                // first loaded parent-to-vertex edge
                if (ef_w == NW'(par_reg) && et_w == NW'(vi_reg) + NW'(1))
                begin
                    w_next     = ewgt_q;
                    state_next = bfspt_pkg::S_PUSHRES;
                end
                else
                begin
                    eidx_next  = eidx_reg + ETW'(1);
                    state_next = bfspt_pkg::S_WRD;
                end
            end
            bfspt_pkg::S_PUSHRES:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_par_next   = pend_par_reg;
                        out_vtx_next   = pend_vtx_reg;
                        out_wgt_next   = pend_wgt_reg;
                        out_found_next = 1'b1;
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_par_next   = TW'(par_reg);
                    pend_vtx_next   = TW'(NW'(vi_reg) + NW'(1));
                    pend_wgt_next   = w_reg;
                    k_next          = k_reg + KW'(1);
                    vi_next         = vi_reg + VW'(1);
                    state_next      = bfspt_pkg::S_VSCAN;
                end
            end
            bfspt_pkg::S_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    out_found_next = pend_valid_reg;
                    out_par_next   = pend_valid_reg ? pend_par_reg : '0;
                    out_vtx_next   = pend_valid_reg ? pend_vtx_reg : '0;
                    out_wgt_next   = pend_valid_reg ? pend_wgt_reg : '0;
                    pend_valid_next = 1'b0;
                    state_next     = bfspt_pkg::S_IDLE;
                end
            end
            default:
                state_next = bfspt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bfspt_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg         <= TW'(1);
            etot_reg       <= '0;
            reached_reg    <= '0;
            fhead_reg      <= '0;
            fcnt_reg       <= '0;
            pcnt_reg       <= '0;
            round_reg      <= '0;
            k_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                vc_reg <= cfg.vertex_count;
            etot_reg       <= etot_next;
            reached_reg    <= reached_next;
            fhead_reg      <= fhead_next;
            fcnt_reg       <= fcnt_next;
            pcnt_reg       <= pcnt_next;
            round_reg      <= round_next;
            k_reg          <= k_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        u_reg        <= u_next;
        x_reg        <= x_next;
        dprev_reg    <= dprev_next;
        w_reg        <= w_next;
        eidx_reg     <= eidx_next;
        vi_reg       <= vi_next;
        par_reg      <= par_next;
        pend_par_reg <= pend_par_next;
        pend_vtx_reg <= pend_vtx_next;
        pend_wgt_reg <= pend_wgt_next;
        out_par_reg  <= out_par_next;
        out_vtx_reg  <= out_vtx_next;
        out_wgt_reg  <= out_wgt_next;
        out_found_reg <= out_found_next;
        out_last_reg <= out_last_next;
    end

    // edge store
    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            efrom_mem[e_waddr] <= req.edge_from;
            eto_mem[e_waddr]   <= req.edge_to;
            ewgt_mem[e_waddr]  <= req.edge_weight;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_re)
        begin
            efrom_q <= efrom_mem[e_raddr];
            eto_q   <= eto_mem[e_raddr];
            ewgt_q  <= ewgt_mem[e_raddr];
        end
    end

    // per-vertex distance, round stamp and parent
    always_ff @(posedge clk)
    begin
        if (d_we)
        begin
            dcur_mem[d_waddr] <= d_wcur;
            dprv_mem[d_waddr] <= d_wprv;
            dupd_mem[d_waddr] <= d_wupd;
            dpar_mem[d_waddr] <= d_wpar;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_re)
        begin
            dcur_q <= dcur_mem[d_raddr];
            dprv_q <= dprv_mem[d_raddr];
            dupd_q <= dupd_mem[d_raddr];
            dpar_q <= dpar_mem[d_raddr];
        end
    end

    // work queue
    always_ff @(posedge clk)
    begin
        if (f_we)
            fifo_mem[f_waddr] <= f_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (f_re)
            fifo_q <= fifo_mem[fhead_reg];
    end

    assign req.ready = (state_reg == bfspt_pkg::S_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp.valid            = out_valid_reg;
    assign rsp.tree_parent      = out_par_reg;
    assign rsp.tree_vertex      = out_vtx_reg;
    assign rsp.tree_edge_weight = out_wgt_reg;
    assign rsp.found            = out_found_reg;
    assign rsp.last             = out_last_reg;

    `BFSPT_ASSERT_NEVER(a_fifo_bound, fcnt_reg > FCW'(FD), "work queue count beyond depth")
    `BFSPT_ASSERT_NEVER(a_edge_bound, etot_reg > ETW'(MAX_EDGES), "edge count beyond store")
    `BFSPT_ASSERT_NEXT(a_relax_marks, state_reg == bfspt_pkg::S_ERLX && take_w, reached_reg[x_reg], "relaxed vertex not marked reached")
    `BFSPT_ASSERT_NEXT(a_final_idle, state_reg == bfspt_pkg::S_FINAL && out_free, state_reg == bfspt_pkg::S_IDLE && out_valid_reg && out_last_reg, "final result did not close the run")

endmodule
